[design/adta_pkg.sv]
// Package: shared constants, types and constant functions of the depth-to-altitude block.
package adta_pkg;

    localparam int DEPTH_W         = 27;
    localparam int DEPTH_FRAC_BITS = 16;
    localparam int HEIGHT_W        = 28;

    // Depth is scaled to units of 1e-10 g/cm2 by a product split into two halves.
    localparam logic [63:0] E10      = 64'd10000000000;
    localparam int          SPLIT    = 17;
    localparam int          HALF_W   = 17;
    localparam logic [HALF_W-1:0] E10_LO = HALF_W'(E10 % (64'd1 << SPLIT));
    localparam logic [HALF_W-1:0] E10_HI = HALF_W'(E10 / (64'd1 << SPLIT));
    localparam int PART_W = DEPTH_W + HALF_W;
    localparam int PROD_W = PART_W + SPLIT;
    localparam int AW     = PROD_W - DEPTH_FRAC_BITS;

    localparam logic [63:0] TOP_E10      = 64'd10120000000000;
    localparam logic [63:0] BOUND1_E10   = 64'd2308269624836;
    localparam logic [63:0] BOUND2_E10   = 64'd94225972083;
    localparam logic [63:0] OFF1_NEG_E10 = 64'd995391872300;
    localparam logic [63:0] SCALE1_E10   = 64'd11120841233223;
    localparam logic [63:0] RATE1_E10    = 64'd1101535373;
    localparam logic [63:0] OFF2_E10     = 64'd14027419991;
    localparam logic [63:0] SCALE2_E10   = 64'd13173859402162;
    localparam logic [63:0] RATE2_E10    = 64'd1586188238;
    localparam logic [63:0] SCALE3_E10   = 64'd7242503723584;
    localparam logic [63:0] RATE3_E10    = 64'd1350052403;
    localparam logic [63:0] LN2_NUM      = (64'd693147180560 * 64'd10000) << 6;

    localparam int LOG_FRAC = 28;
    localparam int P_W      = 6;
    localparam int M_W      = 31;
    localparam int LOG_W    = P_W + LOG_FRAC;
    localparam int K_W      = 30;
    localparam logic [LOG_W-1:0] D_LIMIT = LOG_W'(64'd32 << LOG_FRAC);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(140000000);

    localparam logic [K_W-1:0] K1 = K_W'(LN2_NUM / RATE1_E10);
    localparam logic [K_W-1:0] K2 = K_W'(LN2_NUM / RATE2_E10);
    localparam logic [K_W-1:0] K3 = K_W'(LN2_NUM / RATE3_E10);

    typedef enum logic [1:0] {
        LAYER_LOW  = 2'd0,
        LAYER_MID  = 2'd1,
        LAYER_HIGH = 2'd2
    } layer_t;

    typedef struct packed {
        logic   invalid;
        logic   force_max;
        logic   force_zero;
        layer_t layer;
    } side_t;

    // Same binary log as the hardware chain, evaluated at elaboration for the scales.
    function automatic logic [LOG_W-1:0] log2_const(input logic [63:0] v);
        logic [5:0]  p;
        logic [63:0] m;
        logic [27:0] frac;
        p = 6'd0;
        frac = 28'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        if (p >= 6'd30) begin
            m = v >> (p - 6'd30);
        end else begin
            m = v << (6'd30 - p);
        end
        for (int j = 0; j < LOG_FRAC; j++) begin
            m = (m * m) >> 30;
            frac = {frac[26:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {p, frac};
    endfunction

    localparam logic [LOG_W-1:0] LS1 = log2_const(SCALE1_E10);
    localparam logic [LOG_W-1:0] LS2 = log2_const(SCALE2_E10);
    localparam logic [LOG_W-1:0] LS3 = log2_const(SCALE3_E10);

endpackage

[design/atmospheric_depth_to_altitude.sv]
// Top level of the atmospheric depth to altitude converter.
// One depth (unsigned, fixed point in g/cm2) enters per input transaction on
// in_valid/in_ready and one altitude in millimetres, with the invalid flag,
// leaves per output transaction on out_valid/out_ready.
// The datapath is a single pipeline of 36 register stages: three for depth
// scaling and layer choice, two for the leading-one search and normalization,
// twenty-eight for the squaring chain of the binary log (one 31x31 multiply per
// stage), and three for the log difference, split product and saturation.
// Throughput is one transaction per cycle while the receiver does not stall, set
// by the squaring chain taking a new mantissa every cycle that it advances.
// The whole pipeline advances together while the output register is empty or
// being taken; when the receiver holds out_ready low with a result waiting,
// in_ready falls and every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits; the block accepts input as soon as reset is
// released. A zero depth yields the maximum height with invalid set.
module atmospheric_depth_to_altitude (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [adta_pkg::DEPTH_W-1:0]    depth,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [adta_pkg::HEIGHT_W-1:0]   height_mm,
    output logic                            invalid
);

    logic                          en;
    logic                          a_valid, l_valid;
    logic [adta_pkg::AW-1:0]       a_val;
    logic [adta_pkg::LOG_W-1:0]    l_val;
    adta_pkg::side_t               a_side, l_side;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    adta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .depth    (depth),
        .a_valid  (a_valid),
        .a_val    (a_val),
        .a_side   (a_side)
    );

    adta_log2 u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .a_valid (a_valid),
        .a_val   (a_val),
        .a_side  (a_side),
        .l_valid (l_valid),
        .l_val   (l_val),
        .l_side  (l_side)
    );

    adta_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .l_valid   (l_valid),
        .l_val     (l_val),
        .l_side    (l_side),
        .h_valid   (out_valid),
        .h_val     (height_mm),
        .h_invalid (invalid)
    );

endmodule

[design/adta_front.sv]
// Front end: depth scaling, layer selection and log argument.
module adta_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [adta_pkg::DEPTH_W-1:0]  depth,
    output logic                          a_valid,
    output logic [adta_pkg::AW-1:0]       a_val,
    output adta_pkg::side_t               a_side
);

    logic [adta_pkg::PART_W-1:0] pl_reg, ph_reg;
    logic                        v1_reg, zero1_reg;
    logic [adta_pkg::AW-1:0]     g_reg;
    logic                        v2_reg, zero2_reg;
    logic [adta_pkg::AW-1:0]     a_reg, a_next;
    adta_pkg::side_t             side_reg, side_next;
    logic                        v3_reg;
    logic [adta_pkg::PROD_W-1:0] sum;
    logic [adta_pkg::PROD_W-1:0] g_full;
    logic [63:0]                 g64;
    logic                        top;

    assign sum    = {ph_reg, {adta_pkg::SPLIT{1'b0}}}
                  + {{adta_pkg::SPLIT{1'b0}}, pl_reg};
    assign g_full = sum >> adta_pkg::DEPTH_FRAC_BITS;
    assign g64    = 64'(g_reg);
    assign top    = g64 > adta_pkg::TOP_E10;

    always_comb
    begin
        side_next.invalid    = zero2_reg;
        side_next.force_zero = !zero2_reg && top;
        if (g64 > adta_pkg::BOUND1_E10) begin
            a_next          = adta_pkg::AW'(g64 + adta_pkg::OFF1_NEG_E10);
            side_next.layer = adta_pkg::LAYER_HIGH;
        end else if (g64 > adta_pkg::BOUND2_E10) begin
            a_next          = adta_pkg::AW'(g64 - adta_pkg::OFF2_E10);
            side_next.layer = adta_pkg::LAYER_MID;
        end else begin
            a_next          = g_reg;
            side_next.layer = adta_pkg::LAYER_LOW;
        end
        side_next.force_max = zero2_reg || (!top && a_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            pl_reg    <= adta_pkg::PART_W'(depth) * adta_pkg::PART_W'(adta_pkg::E10_LO);
            ph_reg    <= adta_pkg::PART_W'(depth) * adta_pkg::PART_W'(adta_pkg::E10_HI);
            zero1_reg <= depth == '0;
            g_reg     <= g_full[adta_pkg::AW-1:0];
            zero2_reg <= zero1_reg;
            a_reg     <= a_next;
            side_reg  <= side_next;
        end
    end

    assign a_valid = v3_reg;
    assign a_val   = a_reg;
    assign a_side  = side_reg;

endmodule

[design/adta_log2.sv]
// Pipelined binary log: leading-one search, normalization, one squaring per stage.
module adta_log2 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            a_valid,
    input  logic [adta_pkg::AW-1:0]         a_val,
    input  adta_pkg::side_t                 a_side,
    output logic                            l_valid,
    output logic [adta_pkg::LOG_W-1:0]      l_val,
    output adta_pkg::side_t                 l_side
);

    localparam int N = adta_pkg::LOG_FRAC;

    logic [adta_pkg::AW-1:0]       e_a_reg;
    logic [adta_pkg::P_W-1:0]      e_p_reg, p_enc;
    logic                          e_v_reg;
    adta_pkg::side_t               e_side_reg;
    logic [adta_pkg::AW-1:0]       shifted;

    logic [adta_pkg::M_W-1:0]      m_reg    [0:N];
    logic [adta_pkg::LOG_FRAC-1:0] frac_reg [0:N];
    logic [adta_pkg::P_W-1:0]      p_reg    [0:N];
    logic                          v_reg    [0:N];
    adta_pkg::side_t               side_reg [0:N];

    always_comb
    begin
        p_enc = '0;
        for (int i = 0; i < adta_pkg::AW; i++) begin
            if (a_val[i]) begin
                p_enc = adta_pkg::P_W'(i);
            end
        end
    end

    assign shifted = (e_p_reg >= 6'd30) ? (e_a_reg >> (e_p_reg - 6'd30))
                                        : (e_a_reg << (6'd30 - e_p_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            e_v_reg  <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (en) begin
            e_v_reg  <= a_valid;
            v_reg[0] <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            e_a_reg     <= a_val;
            e_p_reg     <= p_enc;
            e_side_reg  <= a_side;
            m_reg[0]    <= shifted[adta_pkg::M_W-1:0];
            frac_reg[0] <= '0;
            p_reg[0]    <= e_p_reg;
            side_reg[0] <= e_side_reg;
        end
    end

    for (genvar s = 1; s <= N; s++) begin : g_sq
        logic [2*adta_pkg::M_W-1:0] sq;
        logic [adta_pkg::M_W:0]     t;
        assign sq = {{adta_pkg::M_W{1'b0}}, m_reg[s-1]}
                  * {{adta_pkg::M_W{1'b0}}, m_reg[s-1]};
        assign t  = sq[2*adta_pkg::M_W-1:30];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        // A square at or above two halves the mantissa and yields a one bit.
        always_ff @(posedge clk)
        begin
            if (en) begin
                m_reg[s]    <= t[adta_pkg::M_W] ? t[adta_pkg::M_W:1]
                                                : t[adta_pkg::M_W-1:0];
                frac_reg[s] <= {frac_reg[s-1][adta_pkg::LOG_FRAC-2:0], t[adta_pkg::M_W]};
                p_reg[s]    <= p_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign l_valid = v_reg[N];
    assign l_val   = {p_reg[N], frac_reg[N]};
    assign l_side  = side_reg[N];

endmodule

[design/adta_scale.sv]
// Back end: log difference, scaling to millimetres and saturation.
module adta_scale (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             l_valid,
    input  logic [adta_pkg::LOG_W-1:0]       l_val,
    input  adta_pkg::side_t                  l_side,
    output logic                             h_valid,
    output logic [adta_pkg::HEIGHT_W-1:0]    h_val,
    output logic                             h_invalid
);

    localparam int PP_W = adta_pkg::SPLIT + adta_pkg::K_W;

    logic [adta_pkg::LOG_W-1:0]    ls, d_next, d_reg;
    logic [adta_pkg::K_W-1:0]      k, k_reg;
    adta_pkg::side_t               sa_reg, sb_reg;
    logic                          va_reg, vb_reg, vc_reg;
    logic [PP_W-1:0]               pl_reg, ph_reg;
    logic [63:0]                   total;
    logic [29:0]                   h_full;
    logic [adta_pkg::HEIGHT_W-1:0] h_next, h_reg;
    logic                          inv_reg;

    always_comb
    begin
        unique case (l_side.layer)
            adta_pkg::LAYER_HIGH: begin
                ls = adta_pkg::LS1;
                k  = adta_pkg::K1;
            end
            adta_pkg::LAYER_MID: begin
                ls = adta_pkg::LS2;
                k  = adta_pkg::K2;
            end
            default: begin
                ls = adta_pkg::LS3;
                k  = adta_pkg::K3;
            end
        endcase
        if (ls <= l_val) begin
            d_next = '0;
        end else if (ls - l_val > adta_pkg::D_LIMIT) begin
            d_next = adta_pkg::D_LIMIT;
        end else begin
            d_next = ls - l_val;
        end
    end

    assign total  = {ph_reg, {adta_pkg::SPLIT{1'b0}}} + 64'(pl_reg) + (64'd1 << 33);
    assign h_full = total[63:34];

    always_comb
    begin
        priority if (sb_reg.force_max) begin
            h_next = adta_pkg::HEIGHT_MAX;
        end else if (sb_reg.force_zero) begin
            h_next = '0;
        end else if (h_full > 30'(adta_pkg::HEIGHT_MAX)) begin
            h_next = adta_pkg::HEIGHT_MAX;
        end else begin
            h_next = h_full[adta_pkg::HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= l_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d_reg   <= d_next;
            k_reg   <= k;
            sa_reg  <= l_side;
            pl_reg  <= PP_W'(d_reg[adta_pkg::SPLIT-1:0]) * PP_W'(k_reg);
            ph_reg  <= PP_W'(d_reg[adta_pkg::LOG_W-1:adta_pkg::SPLIT]) * PP_W'(k_reg);
            sb_reg  <= sa_reg;
            h_reg   <= h_next;
            inv_reg <= sb_reg.invalid;
        end
    end

    assign h_valid   = vc_reg;
    assign h_val     = h_reg;
    assign h_invalid = inv_reg;

endmodule

[tb/sv/tb_atmospheric_depth_to_altitude.sv]
// Testbench of the depth-to-altitude converter: random and directed depths, checked by a predictor.
module tb_atmospheric_depth_to_altitude;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1800;
    localparam int DEPTH_W = adta_pkg::DEPTH_W;
    localparam int HEIGHT_W = adta_pkg::HEIGHT_W;
    localparam int DEPTH_FRAC_BITS = adta_pkg::DEPTH_FRAC_BITS;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = adta_pkg::HEIGHT_MAX;

    typedef struct {
        logic [HEIGHT_W-1:0] height_mm;
        logic                invalid;
    } altitude_t;

    function automatic logic [63:0] bin_log_q28(input logic [63:0] v);
        logic [5:0]  lead;
        logic [63:0] mant;
        logic [27:0] fbits;
        lead = 6'd0;
        fbits = 28'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                lead = 6'(i);
            end
        end
        if (lead >= 6'd30) begin
            mant = v >> (lead - 6'd30);
        end else begin
            mant = v << (6'd30 - lead);
        end
        for (int j = 0; j < 28; j++) begin
            mant = (mant * mant) >> 30;
            fbits = {fbits[26:0], 1'b0};
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                fbits[0] = 1'b1;
            end
        end
        return {30'd0, lead, fbits};
    endfunction

    function automatic altitude_t predict_altitude(input logic [DEPTH_W-1:0] dep);
        altitude_t r;
        logic [63:0] g, a, s, k, la, ls, d, h;
        r.invalid = 1'b0;
        if (dep == 0) begin
            r.height_mm = HEIGHT_MAX;
            r.invalid = 1'b1;
            return r;
        end
        g = (64'(dep) * 64'd10000000000) >> DEPTH_FRAC_BITS;
        if (g > 64'd10120000000000) begin
            r.height_mm = '0;
            return r;
        end
        if (g > 64'd2308269624836) begin
            a = g + 64'd995391872300;
            s = 64'd11120841233223;
            k = 64'((64'd693147180560 * 64'd10000 << 6) / 64'd1101535373);
        end else if (g > 64'd94225972083) begin
            a = g - 64'd14027419991;
            s = 64'd13173859402162;
            k = 64'((64'd693147180560 * 64'd10000 << 6) / 64'd1586188238);
        end else begin
            a = g;
            s = 64'd7242503723584;
            k = 64'((64'd693147180560 * 64'd10000 << 6) / 64'd1350052403);
        end
        if (a == 0) begin
            r.height_mm = HEIGHT_MAX;
            return r;
        end
        la = bin_log_q28(a);
        ls = bin_log_q28(s);
        d = (ls > la) ? ls - la : 64'd0;
        if (d > (64'd32 << 28)) begin
            d = 64'd32 << 28;
        end
        h = (d * k + (64'd1 << 33)) >> 34;
        if (h > 64'd140000000) begin
            h = 64'd140000000;
        end
        r.height_mm = h[HEIGHT_W-1:0];
        return r;
    endfunction

    class altitude_scoreboard;
        altitude_t pending[$];
        int        errors;

        function void note_depth(logic [DEPTH_W-1:0] dep);
            pending.push_back(predict_altitude(dep));
        endfunction

        function void check_altitude(logic [HEIGHT_W-1:0] hgt, logic inv);
            altitude_t e;
            if (pending.size() == 0) begin
                $error("unexpected result height_mm=%0d invalid=%0b", hgt, inv);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hgt !== e.height_mm) begin
                $error("height_mm expected %0d actual %0d", e.height_mm, hgt);
                errors++;
            end
            if (inv !== e.invalid) begin
                $error("invalid expected %0b actual %0b", e.invalid, inv);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [DEPTH_W-1:0]  depth = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [HEIGHT_W-1:0] height_mm;
    logic                invalid;
    logic                sending_done = 1'b0;
    altitude_scoreboard  sb;

    atmospheric_depth_to_altitude uut (.*);

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Depth codes around the layer boundaries (16 fraction bits).
    localparam logic [DEPTH_W-1:0] TOP_CODE = DEPTH_W'(1012 * 65536);
    localparam logic [DEPTH_W-1:0] B1_CODE  = DEPTH_W'(64'd2308269624836 * 65536 / 64'd10000000000);
    localparam logic [DEPTH_W-1:0] B2_CODE  = DEPTH_W'(64'd94225972083 * 65536 / 64'd10000000000);
    localparam logic [DEPTH_W-1:0] OFF2_CODE = DEPTH_W'(64'd14027419991 * 65536 / 64'd10000000000);

    // in_valid stays high from one transaction into the next when there is no gap.
    task automatic send_depth(input logic [DEPTH_W-1:0] dep, input int gap);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        depth <= dep;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_depth(dep);
    endtask

    function automatic logic [DEPTH_W-1:0] random_depth();
        case ($urandom_range(0, 7))
            0: return DEPTH_W'($urandom);
            1: return DEPTH_W'($urandom_range(0, 64));
            2: return DEPTH_W'(TOP_CODE + $urandom_range(0, 8) - 4);
            3: return DEPTH_W'(B1_CODE + $urandom_range(0, 8) - 4);
            4: return DEPTH_W'(B2_CODE + $urandom_range(0, 8) - 4);
            5: return DEPTH_W'(OFF2_CODE + $urandom_range(0, 8) - 4);
            default: return DEPTH_W'($urandom_range(0, TOP_CODE));
        endcase
    endfunction

    initial begin
        logic [DEPTH_W-1:0] directed[$];
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{'0, 1, 2, 3, {DEPTH_W{1'b1}}, TOP_CODE, TOP_CODE + 1, TOP_CODE - 1,
                     B1_CODE, B1_CODE + 1, B2_CODE, B2_CODE + 1, OFF2_CODE,
                     OFF2_CODE + 1, DEPTH_W'(65536), DEPTH_W'(500 * 65536),
                     DEPTH_W'(27'h2AAAAAA), DEPTH_W'(27'h5555555)};
        foreach (directed[i]) send_depth(directed[i], $urandom_range(0, 4));
        in_valid <= 1'b0;
        // Drain fully once so the pipeline runs empty mid-stream.
        while (sb.pending.size() != 0) @(posedge clk);
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                // Back-to-back burst with no sender gaps.
                send_depth(random_depth(), 0);
            end else begin
                send_depth(random_depth(), $urandom_range(0, 4));
            end
        end
        in_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_altitude(height_mm, invalid);
        end
    end

    // Receiver stalls: per result a random hold with out_ready low, sometimes none at all.
    initial begin
        int hold;
        @(posedge rst_n);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        @(posedge sending_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end
endmodule
